// ----- design/utf8dec_pkg.sv -----
// ---------------------------------------------------------------------------
// utf8dec_pkg: shared types and constants of the UTF-8 to UCS-2 decoder
// Result status codes, sequence length decode and per-length payload masks.
// ---------------------------------------------------------------------------
`default_nettype none

package utf8dec_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STRAY    = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_ABOVE    = 3'd3,
        ST_OVERLONG = 3'd4
    } t_status;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_code;
    typedef logic [31:0] t_acc;
    typedef logic [2:0]  t_count;

    localparam logic [5:0] CONT_MASK = 6'h3F;

    // Sequence length of a lead byte 0xC0-0xFF; bits 1 and 0 of the lead are ignored
    function automatic t_count lead_length(input t_byte b);
        t_count len;
        if (!b[5]) begin
            len = 3'd2;
        end else if (!b[4]) begin
            len = 3'd3;
        end else if (!b[3]) begin
            len = 3'd4;
        end else if (!b[2]) begin
            len = 3'd5;
        end else begin
            len = 3'd6;
        end
        return len;
    endfunction

    // Payload bits kept on completion: low 2 + 5 * length bits
    function automatic t_acc keep_mask(input t_count len);
        t_acc m;
        case (len)
            3'd2:    m = 32'h0000_0FFF;
            3'd3:    m = 32'h0001_FFFF;
            3'd4:    m = 32'h003F_FFFF;
            3'd5:    m = 32'h07FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Smallest value that is not overlong for a given length
    function automatic logic [16:0] min_value(input t_count len);
        logic [16:0] v;
        case (len)
            3'd2:    v = 17'h0_0080;
            3'd3:    v = 17'h0_0800;
            default: v = 17'h1_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/utf8_to_ucs2_decoder.sv -----
// ---------------------------------------------------------------------------
// utf8_to_ucs2_decoder: byte-wise UTF-8 to UCS-2 decoder
// Decodes one UTF-8 byte per transaction and emits a UCS-2 code or an error
// status when a character completes. Results pass through a two-entry queue.
// ---------------------------------------------------------------------------
// Results: each result is registered into the result queue and presented at its head.
// Throughput: one byte per cycle while the result queue is not full; the decode step
//   from the sequence state is a single combinational pass, and the two-entry result
//   queue keeps input flowing while one result waits at the output.
// Reset: synchronous active-low i_rst_n clears the sequence state (idle) and
//   empties the result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Input stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire utf8dec_pkg::t_byte        s_axis_tdata,   // [7:0] text_byte
    // Result stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output utf8dec_pkg::t_code             m_axis_tdata,   // [15:0] code_point
    output logic [2:0]                     m_axis_tuser    // [2:0] status
);

    import utf8dec_pkg::*;

    // Sequence state
    t_acc   r_acc;
    t_acc   n_acc;
    t_count r_rem;
    t_count n_rem;
    t_count r_len;
    t_count n_len;

    // Result of the current byte
    logic    res_valid;
    t_code   res_code;
    t_status res_status;

    logic    is_cont;
    t_acc    acc_shift;
    t_acc    masked;
    logic    in_accept;
    logic    push;
    logic    pop;

    // Result queue
    t_code   r_q_code   [2];
    t_status r_q_status [2];
    logic    r_wr_ptr;
    logic    r_rd_ptr;
    logic [1:0] r_count;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_count != 2'd2);
    assign push          = in_accept && res_valid;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // Decode one byte against the sequence state
    always_comb begin
        is_cont    = (s_axis_tdata[7:6] == 2'b10);
        acc_shift  = {r_acc[25:0], s_axis_tdata[5:0] & CONT_MASK};
        masked     = acc_shift & keep_mask(r_len);
        n_acc      = r_acc;
        n_rem      = r_rem;
        n_len      = r_len;
        res_valid  = 1'b0;
        res_code   = '0;
        res_status = ST_OK;
        if (r_rem != 3'd0) begin
            if (!is_cont) begin
                // drop the byte, close the sequence
                n_rem      = 3'd0;
                res_valid  = 1'b1;
                res_status = ST_TRUNC;
            end else begin
                n_acc = acc_shift;
                n_rem = r_rem - 3'd1;
                if (r_rem == 3'd1) begin
                    res_valid = 1'b1;
                    if (masked[31:16] != 16'h0) begin
                        res_status = ST_ABOVE;
                    end else if ({1'b0, masked[15:0]} < min_value(r_len)) begin
                        res_status = ST_OVERLONG;
                    end else begin
                        res_code = masked[15:0];
                    end
                end
            end
        end else if (!s_axis_tdata[7]) begin
            res_valid = 1'b1;
            res_code  = {8'h00, s_axis_tdata};
        end else if (is_cont) begin
            res_valid  = 1'b1;
            res_status = ST_STRAY;
        end else begin
            // open a multi-byte sequence
            n_acc = {24'h0, s_axis_tdata};
            n_len = lead_length(s_axis_tdata);
            n_rem = n_len - 3'd1;
        end
    end

    // Advance the sequence state on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_rem <= '0;
            r_len <= '0;
        end else if (in_accept) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_len <= n_len;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_code[r_wr_ptr]   <= res_code;
            r_q_status[r_wr_ptr] <= res_status;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Present the queue head
    assign m_axis_tvalid = (r_count != 2'd0);
    assign m_axis_tdata  = r_q_code[r_rd_ptr];
    assign m_axis_tuser  = r_q_status[r_rd_ptr];

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue overfilled");

    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != 3'd0) |-> (r_rem < r_len))
        else $error("continuation count exceeds sequence length");

    a_error_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == 16'h0))
        else $error("error result carries a nonzero code");

    a_lead_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (r_rem == 3'd0) && (s_axis_tdata[7:6] == 2'b11))
        |=> (r_rem != 3'd0))
        else $error("lead byte did not open a sequence");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: regression bench for the UTF-8 to UCS-2 decoder
// Streams UTF-8 bytes into the decoder with random gaps and output stalls,
// predicts every code or error status in a scoreboard and checks each
// result transaction in order against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import utf8dec_pkg::*;

    localparam int BYTE_TARGET = 1600;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct {
        t_code   code;
        t_status status;
    } t_ucs2_result;

    // Tracks the decoder's sequence state and holds the results still owed
    class ucs2_scoreboard;
        t_acc          payload = '0;
        t_count        cont_left = '0;
        t_count        seq_len = '0;
        t_ucs2_result  owed_results[$];
        int            fail_count = 0;
        int            checked = 0;
        int            status_seen[5] = '{default: 0};

        task report(input string msg);
            $display("MISMATCH: %s", msg);
            fail_count++;
        endtask

        function int outstanding();
            return owed_results.size();
        endfunction

        // Advance the sequence state by one accepted byte
        function void note_byte(input t_byte b);
            bit           is_cont;
            bit           gives_result;
            bit           run;
            t_acc         kept;
            t_ucs2_result r;
            is_cont      = (b[7:6] == 2'b10);
            gives_result = 1'b1;
            r.code       = '0;
            r.status     = ST_OK;
            if (cont_left != 0) begin
                if (!is_cont) begin
                    // Drop the offending byte and fall back to idle
                    cont_left = '0;
                    r.status  = ST_TRUNC;
                end else begin
                    payload   = (payload << 6) + {26'd0, b[5:0]};
                    cont_left = cont_left - 3'd1;
                    if (cont_left != 0) begin
                        gives_result = 1'b0;
                    end else begin
                        if (seq_len >= 3'd6 || seq_len < 3'd2) begin
                            kept = payload;
                        end else begin
                            kept = payload & ((32'd1 << (2 + 5 * int'(seq_len))) - 32'd1);
                        end
                        if (kept > 32'h0000_FFFF) begin
                            r.status = ST_ABOVE;
                        end else if ((seq_len == 3'd2 && kept < 32'h80) ||
                                     (seq_len == 3'd3 && kept < 32'h800) ||
                                     (seq_len != 3'd2 && seq_len != 3'd3)) begin
                            r.status = ST_OVERLONG;
                        end else begin
                            r.code = kept[15:0];
                        end
                    end
                end
            end else if (!b[7]) begin
                r.code = {8'd0, b};
            end else if (is_cont) begin
                r.status = ST_STRAY;
            end else begin
                // Lead byte: length from the run of ones below bit 6, bits 1 and 0 ignored
                seq_len = 3'd2;
                run     = 1'b1;
                for (int i = 5; i >= 2; i--) begin
                    if (run && b[i]) begin
                        seq_len = seq_len + 3'd1;
                    end else begin
                        run = 1'b0;
                    end
                end
                payload      = {24'd0, b};
                cont_left    = seq_len - 3'd1;
                gives_result = 1'b0;
            end
            if (gives_result) begin
                owed_results.push_back(r);
            end
        endfunction

        // Compare one result transaction with the oldest owed result
        task check_result(input t_code code, input logic [2:0] status);
            t_ucs2_result r;
            checked++;
            if (status <= ST_OVERLONG) begin
                status_seen[status]++;
            end
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result code %h status %0d", code, status));
            end else begin
                r = owed_results.pop_front();
                if (code !== r.code) begin
                    report($sformatf("result %0d code %h, want %h", checked, code, r.code));
                end
                if (status !== r.status) begin
                    report($sformatf("result %0d status %0d, want %0d",
                                     checked, status, r.status));
                end
            end
        endtask
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    s_axis_tvalid = 1'b0;
    logic    s_axis_tready;
    t_byte   s_axis_tdata = '0;
    logic    m_axis_tvalid;
    logic    m_axis_tready = 1'b0;
    t_code   m_axis_tdata;
    logic [2:0] m_axis_tuser;

    ucs2_scoreboard sb;
    bit      quiet = 1'b0;
    int      bytes_sent = 0;
    int      cycles = 0;
    int      stall_left = 0;

    // Directed bytes: ASCII extremes, stray continuations, two- and three-byte boundaries,
    // overlong forms, a value above 0xFFFF, a 0xFF lead, a truncation
    t_byte directed_bytes [0:31] = '{
        8'h00, 8'h7F, 8'h80, 8'hBF,
        8'hC2, 8'h80,
        8'hC0, 8'h80,
        8'hDF, 8'hBF,
        8'hE0, 8'h80, 8'h80,
        8'hEF, 8'hBF, 8'hBF,
        8'hF0, 8'h90, 8'h80, 8'h80,
        8'hF0, 8'h80, 8'h80, 8'h80,
        8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'hC2, 8'h41
    };

    utf8_to_ucs2_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= pick_gap();
        end
    end

    // Check each result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("utf8_to_ucs2_decoder regression: fail");
            $finish;
        end
    end

    // Present one byte, hold it until accepted, then predict its result
    task automatic send_byte(input t_byte b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Hold the input idle until every owed result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed sequences with random payload, some noise and cut-offs
    task automatic send_random_piece();
        int    kind;
        int    r;
        int    len;
        int    cont;
        t_byte lead;
        t_byte cb;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            send_byte(t_byte'($urandom_range(0, 255)));
        end else begin
            r = $urandom_range(0, 99);
            len = (r < 30) ? 1 : (r < 55) ? 2 : (r < 75) ? 3 : (r < 85) ? 4 : (r < 92) ? 5 : 6;
            lead = t_byte'($urandom_range(0, 255));
            case (len)
                1:       lead = {1'b0, lead[6:0]};
                2:       lead = {3'b110, lead[4:0]};
                3:       lead = {4'b1110, lead[3:0]};
                4:       lead = {5'b11110, lead[2:0]};
                5:       lead = {6'b111110, lead[1:0]};
                default: lead = {6'b111111, lead[1:0]};
            endcase
            cont = len - 1;
            if (kind < 18 && cont > 0) begin
                cont = $urandom_range(0, cont - 1);
            end
            send_byte(lead);
            repeat (cont) begin
                cb = t_byte'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0) begin
                    cb = 8'h80;
                end
                send_byte({2'b10, cb[5:0]});
            end
        end
    endtask

    initial begin
        sb = new;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[k]) begin
            send_byte(directed_bytes[k]);
        end
        drain_results();

        // Full-rate stretch with no idling on either side
        quiet = 1'b1;
        while (bytes_sent < 250) send_random_piece();
        quiet = 1'b0;

        while (bytes_sent < BYTE_TARGET) begin
            send_random_piece();
            if ($urandom_range(0, 99) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes, checked %0d results", bytes_sent, sb.checked);
        $display("ok %0d, stray %0d, truncated %0d, above %0d, overlong %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_STRAY], sb.status_seen[ST_TRUNC],
                 sb.status_seen[ST_ABOVE], sb.status_seen[ST_OVERLONG]);
        if (sb.fail_count == 0) begin
            $display("utf8_to_ucs2_decoder regression: pass");
        end else begin
            $display("utf8_to_ucs2_decoder regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/utf8dec_pkg.sv
design/utf8_to_ucs2_decoder.sv
verif/tb_top.sv
